// File: rtl/ulv_pkg.sv
// Shared types, constants and code point rules for the UTF-8 label validator.
package ulv_pkg;

    // Field widths of the stream words.
    localparam int unsigned ByteW = 8;
    localparam int unsigned LenW  = 7;
    localparam int unsigned CpW   = 21;

    // Code point limits used by the decoder.
    localparam logic [CpW-1:0] CpMax      = 21'h10ffff;
    localparam logic [CpW-1:0] SurrogLo   = 21'h00d800;
    localparam logic [CpW-1:0] SurrogHi   = 21'h00dfff;

    // Lead byte bounds.
    localparam logic [ByteW-1:0] Lead2Lo  = 8'hc2;
    localparam logic [ByteW-1:0] Lead4Hi  = 8'hf4;

    typedef logic [CpW-1:0]   t_cp;
    typedef logic [LenW-1:0]  t_len;
    typedef logic [ByteW-1:0] t_byte;

    // Smallest code point that a sequence of the given length may encode.
    function automatic t_cp min_cp(input logic [1:0] seq);
        t_cp m;
        case (seq)
            2'd0:    m = 21'h000000;
            2'd1:    m = 21'h000080;
            2'd2:    m = 21'h000800;
            2'd3:    m = 21'h010000;
            default: m = 21'h000000;
        endcase
        return m;
    endfunction

    // Label character rules: allowed ASCII set and denied Unicode ranges.
    function automatic logic cp_allowed(input t_cp c);
        logic ok;
        if (c < 21'h20 || c inside {[21'h7f:21'h9f]}) begin
            ok = 1'b0;
        end else if (c < 21'h80) begin
            ok = c inside {[21'h41:21'h5a], [21'h61:21'h7a], [21'h30:21'h39],
                           21'h20, 21'h5f, 21'h2d, 21'h2e};
        end else begin
            ok = !(c inside {[21'h00a0:21'h00bf], [21'h2000:21'h2fff],
                             [21'h1f000:21'h1ffff], [21'hfe00:21'hfeff],
                             [21'he0000:21'he0fff], [21'h202a:21'h202e],
                             [21'h2066:21'h2069]});
        end
        return ok;
    endfunction

    // Whitespace code points.
    function automatic logic cp_space(input t_cp c);
        return c inside {21'h20, 21'ha0, [21'h2000:21'h200a], 21'h2028, 21'h2029,
                         21'h202f, 21'h205f, 21'h3000};
    endfunction

endpackage

// File: rtl/utf8_label_validator_unit.sv
// Top level of the UTF-8 label validator: input register, decoder, verdict register.
//
// Usage:
// The slave channel carries one label byte per word in s_axis_tdata; a word
// with s_axis_tlast high carries no byte and closes the label. The master
// channel returns one word per closed label: bit 0 is the verdict (1 = valid)
// and bits 7:1 the byte count, which saturates one above the maximum length
// (and never above 127).
// Throughput is one word per cycle unless an end word waits on a full verdict
// register: the decoder state follows the input register word by word, so
// bytes stream back to back. The verdict shows on m_axis_tvalid once its end
// word has passed the input register and then been loaded into the verdict
// register.
// When the receiver stalls, the verdict waits in its register; byte words
// keep flowing, and only a further end word waits in the input register
// until the verdict is taken.
// Reset (synchronous, active low) empties both registers and clears the
// decoder state; the decoder state clears again after every verdict.
module utf8_label_validator_unit #(
    parameter int unsigned MAX_LABEL_BYTES = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Slave channel.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  ulv_pkg::t_byte     s_axis_tdata,   // [7:0] label_byte
    input  logic               s_axis_tlast,   // end_of_label
    // Master channel.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata    // [0] label_valid, [7:1] byte_total
);
    import ulv_pkg::*;

    // Counter saturation point: one above the maximum, capped by the count width.
    localparam int unsigned CountLimitInt =
        (MAX_LABEL_BYTES + 1 > (2**LenW) - 1) ? (2**LenW) - 1 : MAX_LABEL_BYTES + 1;
    localparam t_len        CountLimit = LenW'(CountLimitInt);
    localparam logic [7:0]  MaxBytes   = 8'(MAX_LABEL_BYTES);

    // Input register.
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    // Decoder state.
    t_len       r_byte_count, n_byte_count;
    logic [1:0] r_pending, n_pending;
    logic [1:0] r_seq_len, n_seq_len;
    t_cp        r_partial, n_partial;
    logic       r_error, n_error;
    logic       r_first_seen, n_first_seen;
    logic       r_first_space, n_first_space;
    logic       r_last_space, n_last_space;
    logic       r_content, n_content;

    // Verdict register.
    logic       r_out_valid;
    logic       r_out_ok;
    t_len       r_out_len;

    logic       advance;
    logic       fin;
    t_cp        fin_cp;
    logic [1:0] fin_seq;
    logic       fin_bad;
    logic       fin_space;
    t_cp        cont_cp;
    logic       verdict;

    // Handshake: the decoder moves on unless an end word waits for a full verdict slot.
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Continuation byte appended to the gathered bits.
    assign cont_cp = {r_partial[CpW-7:0], r_in_byte[5:0]};

    // Next decoder state for one byte or an end word.
    always_comb begin
        n_byte_count  = r_byte_count;
        n_pending     = r_pending;
        n_seq_len     = r_seq_len;
        n_partial     = r_partial;
        n_error       = r_error;
        n_first_seen  = r_first_seen;
        n_first_space = r_first_space;
        n_last_space  = r_last_space;
        n_content     = r_content;
        fin           = 1'b0;
        fin_cp        = '0;
        fin_seq       = 2'd0;
        fin_bad       = 1'b0;
        fin_space     = 1'b0;
        if (r_in_last) begin
            n_byte_count  = '0;
            n_pending     = 2'd0;
            n_seq_len     = 2'd0;
            n_partial     = '0;
            n_error       = 1'b0;
            n_first_seen  = 1'b0;
            n_first_space = 1'b0;
            n_last_space  = 1'b0;
            n_content     = 1'b0;
        end else begin
            if (r_byte_count < CountLimit) begin
                n_byte_count = r_byte_count + 1'b1;
            end
            if (!r_error) begin
                if (r_pending != 2'd0) begin
                    if (r_in_byte[7:6] != 2'b10) begin
                        n_error = 1'b1;
                    end else begin
                        n_partial = cont_cp;
                        n_pending = r_pending - 1'b1;
                        if (r_pending == 2'd1) begin
                            fin     = 1'b1;
                            fin_cp  = cont_cp;
                            fin_seq = r_seq_len;
                        end
                    end
                end else if (!r_in_byte[7]) begin
                    n_seq_len = 2'd0;
                    fin       = 1'b1;
                    fin_cp    = CpW'(r_in_byte);
                    fin_seq   = 2'd0;
                end else if (r_in_byte >= Lead2Lo && r_in_byte <= 8'hdf) begin
                    n_partial = CpW'(r_in_byte[4:0]);
                    n_seq_len = 2'd1;
                    n_pending = 2'd1;
                end else if (r_in_byte >= 8'he0 && r_in_byte <= 8'hef) begin
                    n_partial = CpW'(r_in_byte[3:0]);
                    n_seq_len = 2'd2;
                    n_pending = 2'd2;
                end else if (r_in_byte >= 8'hf0 && r_in_byte <= Lead4Hi) begin
                    n_partial = CpW'(r_in_byte[2:0]);
                    n_seq_len = 2'd3;
                    n_pending = 2'd3;
                end else begin
                    n_error = 1'b1;
                end
            end
            // Checks on a finished code point.
            fin_bad   = (fin_cp < min_cp(fin_seq)) || (fin_cp > CpMax) ||
                        (fin_cp >= SurrogLo && fin_cp <= SurrogHi) || !cp_allowed(fin_cp);
            fin_space = cp_space(fin_cp);
            // Record the finished code point.
            if (fin) begin
                if (fin_bad) begin
                    n_error = 1'b1;
                end else begin
                    if (!r_first_seen) begin
                        n_first_seen  = 1'b1;
                        n_first_space = fin_space;
                    end
                    n_last_space = fin_space;
                    if (!fin_space) begin
                        n_content = 1'b1;
                    end
                end
            end
        end
    end

    // Verdict from the state before the end word.
    assign verdict = (r_byte_count == '0) ||
                     (!r_error && r_pending == 2'd0 && ({1'b0, r_byte_count} <= MaxBytes) &&
                      r_content && !r_first_space && !r_last_space);

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_pending     <= 2'd0;
            r_seq_len     <= 2'd0;
            r_partial     <= '0;
            r_error       <= 1'b0;
            r_first_seen  <= 1'b0;
            r_first_space <= 1'b0;
            r_last_space  <= 1'b0;
            r_content     <= 1'b0;
        end else if (advance) begin
            r_byte_count  <= n_byte_count;
            r_pending     <= n_pending;
            r_seq_len     <= n_seq_len;
            r_partial     <= n_partial;
            r_error       <= n_error;
            r_first_seen  <= n_first_seen;
            r_first_space <= n_first_space;
            r_last_space  <= n_last_space;
            r_content     <= n_content;
        end
    end

    // Verdict register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_ok  <= verdict;
            r_out_len <= r_byte_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_ok};

    // The byte count never passes its saturation point.
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CountLimit)
        else $error("byte count beyond saturation point");

    // The decoder state is clear after every end word.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_byte_count == '0 && r_pending == 2'd0 && !r_error)
        else $error("decoder state not cleared after verdict");

    // Pending continuations never exceed the length of the current sequence.
    a_pending_le_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= r_seq_len)
        else $error("pending continuations exceed sequence length");

    // A valid verdict never comes with a length above the maximum.
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ok |-> {1'b0, r_out_len} <= MaxBytes)
        else $error("valid verdict with excessive length");

endmodule
